### design/pctm_pkg.sv
`default_nettype none

package pctm_pkg;

	// Field widths
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned ERR_W  = 33;
	localparam int unsigned DERR_W = 34;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned INT_W  = 16;
	localparam int unsigned OMAX_W = 15;
	localparam int unsigned ACC_W  = 40;
	localparam int unsigned PROD_W = 50;
	localparam int unsigned SUM_W  = 52;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned FRAC_W = 8;

	// Control law codes
	localparam logic [1:0] MODE_POS   = 2'd0;
	localparam logic [1:0] MODE_SPEED = 2'd1;
	localparam logic [1:0] MODE_INCR  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OMAX   = 3'd4;

	// Limits
	localparam logic signed [INT_W-1:0] POS_INT_MAX = 16'sd20000;
	localparam logic signed [INT_W-1:0] POS_INT_MIN = -16'sd20000;
	localparam logic signed [INT_W-1:0] SPD_INT_MAX = 16'sd10000;
	localparam logic signed [INT_W-1:0] SPD_INT_MIN = -16'sd10000;
	localparam logic [OMAX_W-1:0] OMAX_RESET = 15'd6000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;

endpackage

`default_nettype wire

### design/pid_controller_three_mode.sv
// Three-mode fixed-point PID controller.
// Input channel s_axis carries one sample item: measured and target values.
// Output channel m_axis returns one drive item per sample, in order.
// The cfg write channel sets mode, gains (Q8.8) and the output clamp; it is
// always ready. It must be written only while no sample is in flight; the block itself does not enforce this.
// Modes: 0 positional PID, 1 speed PI, 2 incremental PI, 3 drives 0.
// Pipeline: input register, error/integral stage, multiply stage, then the
// sum/clamp/accumulate stage that loads the output register. Throughput is
// one item per cycle while the receiver keeps m_axis_tready high. Integral
// and previous error update in the second stage and the accumulator in the
// last, so each state loop closes within its own stage.
// Each stage advances into a free or draining next stage, so bubbles fill
// while the receiver stalls; with all four stages full, s_axis_tready drops.
// Reset clears all valid flags, integral, previous error and accumulator,
// and loads mode 0, zero gains and an output clamp of 6000.
`default_nettype none

module pid_controller_three_mode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] measured, [63:32] target
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] drive
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [pctm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pctm_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [1:0]                                mode_q;
	logic signed [pctm_pkg::GAIN_W-1:0]        gain_p_q;
	logic signed [pctm_pkg::GAIN_W-1:0]        gain_i_q;
	logic signed [pctm_pkg::GAIN_W-1:0]        gain_d_q;
	logic [pctm_pkg::OMAX_W-1:0]               omax_q;

	// Controller state
	logic signed [pctm_pkg::INT_W-1:0]         integ_q;
	logic signed [pctm_pkg::ERR_W-1:0]         prev_err_q;
	logic signed [pctm_pkg::ACC_W-1:0]         acc_q;

	// Pipeline registers
	logic                                      v_s1, v_s2, v_s3, v_s4;
	logic signed [pctm_pkg::VAL_W-1:0]         meas_s1, targ_s1;
	logic signed [pctm_pkg::ERR_W-1:0]         err_s2;
	logic signed [pctm_pkg::DERR_W-1:0]        derr_s2;
	logic signed [pctm_pkg::INT_W-1:0]         integ_s2;
	logic signed [pctm_pkg::PROD_W-1:0]        pa_s3, pb_s3, pd_s3;
	logic [pctm_pkg::VAL_W-1:0]                drive_s4;

	// Stage advance
	logic adv1, adv2, adv3, adv4;

	assign adv4 = v_s3 && (!v_s4 || m_axis_tready);
	assign adv3 = v_s2 && (!v_s3 || adv4);
	assign adv2 = v_s1 && (!v_s2 || adv3);
	assign adv1 = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = !v_s1 || adv2;
	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = drive_s4;
	assign cfg_ready     = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= pctm_pkg::MODE_POS;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			omax_q   <= pctm_pkg::OMAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pctm_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				pctm_pkg::REG_GAIN_P: gain_p_q <= cfg_data;
				pctm_pkg::REG_GAIN_I: gain_i_q <= cfg_data;
				pctm_pkg::REG_GAIN_D: gain_d_q <= cfg_data;
				pctm_pkg::REG_OMAX:   omax_q   <= cfg_data[pctm_pkg::OMAX_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 2 logic: error, error delta, integral update
	logic signed [pctm_pkg::ERR_W-1:0]   err_c;
	logic signed [pctm_pkg::DERR_W-1:0]  derr_c;
	logic signed [pctm_pkg::DERR_W-1:0]  isum_c;
	logic signed [pctm_pkg::INT_W-1:0]   integ_c;

	always_comb begin
		err_c  = pctm_pkg::ERR_W'(targ_s1) - pctm_pkg::ERR_W'(meas_s1);
		derr_c = pctm_pkg::DERR_W'(err_c) - pctm_pkg::DERR_W'(prev_err_q);
		isum_c = pctm_pkg::DERR_W'(integ_q) + pctm_pkg::DERR_W'(err_c);
		case (mode_q)
			pctm_pkg::MODE_POS: begin
				if (isum_c > pctm_pkg::DERR_W'(pctm_pkg::POS_INT_MAX))
					integ_c = pctm_pkg::POS_INT_MAX;
				else if (isum_c < pctm_pkg::DERR_W'(pctm_pkg::POS_INT_MIN))
					integ_c = pctm_pkg::POS_INT_MIN;
				else
					integ_c = isum_c[pctm_pkg::INT_W-1:0];
			end
			pctm_pkg::MODE_SPEED: begin
				// zero error drops the integral
				if (err_c == '0)
					integ_c = '0;
				else if (isum_c > pctm_pkg::DERR_W'(pctm_pkg::SPD_INT_MAX))
					integ_c = pctm_pkg::SPD_INT_MAX;
				else if (isum_c < pctm_pkg::DERR_W'(pctm_pkg::SPD_INT_MIN))
					integ_c = pctm_pkg::SPD_INT_MIN;
				else
					integ_c = isum_c[pctm_pkg::INT_W-1:0];
			end
			default: integ_c = integ_q;
		endcase
	end

	// Stage 3 logic: gain products
	logic signed [pctm_pkg::PROD_W-1:0] pa_c, pb_c, pd_c;

	always_comb begin
		if (mode_q == pctm_pkg::MODE_INCR) begin
			pa_c = pctm_pkg::PROD_W'(gain_p_q) * pctm_pkg::PROD_W'(derr_s2);
			pb_c = pctm_pkg::PROD_W'(gain_i_q) * pctm_pkg::PROD_W'(err_s2);
		end else begin
			pa_c = pctm_pkg::PROD_W'(gain_p_q) * pctm_pkg::PROD_W'(err_s2);
			pb_c = pctm_pkg::PROD_W'(gain_i_q) * pctm_pkg::PROD_W'(integ_s2);
		end
		if (mode_q == pctm_pkg::MODE_POS)
			pd_c = pctm_pkg::PROD_W'(gain_d_q) * pctm_pkg::PROD_W'(derr_s2);
		else
			pd_c = '0;
	end

	// Stage 4 logic: sum, shift, clamp or accumulate
	logic signed [pctm_pkg::SUM_W-1:0] sum_c;
	logic signed [pctm_pkg::SUM_W-1:0] shifted_c;
	logic signed [pctm_pkg::SUM_W-1:0] asum_c;
	logic signed [pctm_pkg::ACC_W-1:0] acc_c;
	logic signed [pctm_pkg::ACC_W-1:0] acc_sh_c;
	logic [pctm_pkg::VAL_W-1:0]        drive_c;

	always_comb begin
		sum_c = pctm_pkg::SUM_W'(pa_s3) + pctm_pkg::SUM_W'(pb_s3)
			+ pctm_pkg::SUM_W'(pd_s3);
		shifted_c = sum_c >>> pctm_pkg::FRAC_W;
		asum_c = pctm_pkg::SUM_W'(acc_q) + sum_c;
		if (asum_c > pctm_pkg::SUM_W'(pctm_pkg::ACC_MAX))
			acc_c = pctm_pkg::ACC_MAX;
		else if (asum_c < pctm_pkg::SUM_W'(pctm_pkg::ACC_MIN))
			acc_c = pctm_pkg::ACC_MIN;
		else
			acc_c = asum_c[pctm_pkg::ACC_W-1:0];
		acc_sh_c = acc_c >>> pctm_pkg::FRAC_W;
		case (mode_q) inside
			pctm_pkg::MODE_POS, pctm_pkg::MODE_SPEED: begin
				if (shifted_c < 0)
					drive_c = '0;
				else if (shifted_c > $signed({1'b0, pctm_pkg::SUM_W'(omax_q)}))
					drive_c = pctm_pkg::VAL_W'(omax_q);
				else
					drive_c = shifted_c[pctm_pkg::VAL_W-1:0];
			end
			pctm_pkg::MODE_INCR: drive_c = acc_sh_c[pctm_pkg::VAL_W-1:0];
			default: drive_c = '0;
		endcase
	end

	// Advance valid flags and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			integ_q    <= '0;
			prev_err_q <= '0;
			acc_q      <= '0;
		end else begin
			if (adv1)
				v_s1 <= 1'b1;
			else if (adv2)
				v_s1 <= 1'b0;
			if (adv2)
				v_s2 <= 1'b1;
			else if (adv3)
				v_s2 <= 1'b0;
			if (adv3)
				v_s3 <= 1'b1;
			else if (adv4)
				v_s3 <= 1'b0;
			if (adv4)
				v_s4 <= 1'b1;
			else if (m_axis_tready)
				v_s4 <= 1'b0;
			if (adv2) begin
				integ_q <= integ_c;
				if (mode_q == pctm_pkg::MODE_POS || mode_q == pctm_pkg::MODE_INCR)
					prev_err_q <= err_c;
			end
			if (adv4 && mode_q == pctm_pkg::MODE_INCR)
				acc_q <= acc_c;
		end
	end

	// Load payload registers
	always_ff @(posedge clk) begin
		if (adv1) begin
			meas_s1 <= s_axis_tdata[31:0];
			targ_s1 <= s_axis_tdata[63:32];
		end
		if (adv2) begin
			err_s2   <= err_c;
			derr_s2  <= derr_c;
			integ_s2 <= integ_c;
		end
		if (adv3) begin
			pa_s3 <= pa_c;
			pb_s3 <= pb_c;
			pd_s3 <= pd_c;
		end
		if (adv4)
			drive_s4 <= drive_c;
	end

endmodule

`default_nettype wire

### tb/pid_controller_three_mode_tb.sv
`timescale 1ns / 100ps

module pid_controller_three_mode_tb;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 410;

	// mode 3 is not a control law: the block must drive 0 and hold its state
	localparam logic [1:0]                     MODE_SPARE    = 2'd3;
	// index with no register behind it
	localparam logic [pctm_pkg::CFG_IDX_W-1:0] REG_NOT_FOUND = 3'd7;

	typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_EVERY_FOURTH, RX_STARVED} rx_pattern_t;

	logic                            clk;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [63:0]                     s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [31:0]                     m_axis_tdata;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [pctm_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [pctm_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

	pid_controller_three_mode dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Controller copy: registers and shared state
	logic [1:0]                         law        = pctm_pkg::MODE_POS;
	logic signed [pctm_pkg::GAIN_W-1:0] kp         = '0;
	logic signed [pctm_pkg::GAIN_W-1:0] ki         = '0;
	logic signed [pctm_pkg::GAIN_W-1:0] kd         = '0;
	logic [pctm_pkg::OMAX_W-1:0]        drive_max  = pctm_pkg::OMAX_RESET;
	longint                             integ      = 0;
	longint                             last_err   = 0;
	longint                             drive_acc  = 0;

	logic [31:0] expected_drive[$];
	int          failures     = 0;
	int          drives_seen  = 0;
	int          samples_sent = 0;
	int          reg_writes   = 0;
	int          law_items[4] = '{0, 0, 0, 0};
	int          burst_left   = 0;
	int          stalled_cycles = 0;
	bit          quiet        = 1'b0;

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the controller copy by one sample and return the drive it yields
	function automatic logic [31:0] predict_drive(logic signed [31:0] meas,
			logic signed [31:0] tgt);
		longint err;
		longint sum;
		longint drive;
		err   = longint'(tgt) - longint'(meas);
		drive = 0;
		law_items[law]++;
		case (law)
			pctm_pkg::MODE_POS: begin
				integ = clip(integ + err, longint'(pctm_pkg::POS_INT_MIN),
					longint'(pctm_pkg::POS_INT_MAX));
				sum   = longint'(kp) * err + longint'(ki) * integ
					+ longint'(kd) * (err - last_err);
				drive = clip(sum >>> pctm_pkg::FRAC_W, 0, longint'(drive_max));
				last_err = err;
			end
			pctm_pkg::MODE_SPEED: begin
				if (err == 0)
					integ = 0;
				integ = clip(integ + err, longint'(pctm_pkg::SPD_INT_MIN),
					longint'(pctm_pkg::SPD_INT_MAX));
				sum   = longint'(kp) * err + longint'(ki) * integ;
				drive = clip(sum >>> pctm_pkg::FRAC_W, 0, longint'(drive_max));
			end
			pctm_pkg::MODE_INCR: begin
				sum = longint'(kp) * (err - last_err) + longint'(ki) * err;
				drive_acc = clip(drive_acc + sum, longint'(pctm_pkg::ACC_MIN),
					longint'(pctm_pkg::ACC_MAX));
				drive = drive_acc >>> pctm_pkg::FRAC_W;
				last_err = err;
			end
			default: begin
				drive = 0;
			end
		endcase
		return drive[31:0];
	endfunction

	// Send one sample item, with bursts and random gaps ahead of it
	task automatic send_sample(input logic [31:0] meas, input logic [31:0] tgt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tgt, meas};
		do @(negedge clk); while (s_axis_tready !== 1'b1);
		@(posedge clk);
		expected_drive.push_back(predict_drive(meas, tgt));
		samples_sent++;
	endtask

	// Hold the sender and wait until the pipeline is empty
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller lowers cfg_valid after the last write
	task automatic write_reg(input logic [pctm_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		reg_writes++;
		case (idx)
			pctm_pkg::REG_MODE:   law       = value[1:0];
			pctm_pkg::REG_GAIN_P: kp        = value;
			pctm_pkg::REG_GAIN_I: ki        = value;
			pctm_pkg::REG_GAIN_D: kd        = value;
			pctm_pkg::REG_OMAX:   drive_max = value[pctm_pkg::OMAX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_controller(input logic [15:0] mode_word, input logic [15:0] p,
			input logic [15:0] i, input logic [15:0] d, input logic [15:0] omax_word);
		drain_pipeline();
		write_reg(pctm_pkg::REG_MODE, mode_word);
		write_reg(pctm_pkg::REG_GAIN_P, p);
		write_reg(pctm_pkg::REG_GAIN_I, i);
		write_reg(pctm_pkg::REG_GAIN_D, d);
		write_reg(pctm_pkg::REG_OMAX, omax_word);
		cfg_valid <= 1'b0;
	endtask

	// Reset values: zero gains give zero drive, integral still moves
	task automatic test_reset_state();
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h0000_0000, 32'h0000_0000);
	endtask

	// Positional PID: both integral clamps, output clamp at 0 and at its top
	task automatic test_positional();
		program_controller(16'(pctm_pkg::MODE_POS), 16'd256, 16'd16, 16'd128, 16'd32767);
		send_sample(32'd0, 32'd100);
		send_sample(32'd100, 32'd0);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'd5, 32'd5);
		program_controller(16'(pctm_pkg::MODE_POS), 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
		send_sample(32'hFFFF_FF00, 32'h0000_0100);
	endtask

	// Speed PI: large integral left by positional mode, zero error clears it
	task automatic test_speed();
		program_controller(16'(pctm_pkg::MODE_POS), 16'd0, 16'd0, 16'd0, 16'd6000);
		send_sample(32'd0, 32'd30000);
		program_controller(16'(pctm_pkg::MODE_SPEED), 16'd256, 16'd256, 16'd0, 16'd0);
		send_sample(32'd0, 32'd50);
		program_controller(16'(pctm_pkg::MODE_SPEED), 16'd256, 16'd256, 16'd0, 16'd32767);
		send_sample(32'd1000, 32'd1500);
		send_sample(32'hFFFF_FFF0, 32'hFFFF_FFF0);
		send_sample(32'd20000, 32'd0);
	endtask

	// Incremental PI: drive the accumulator into both saturation limits
	task automatic test_incremental();
		program_controller(16'(pctm_pkg::MODE_INCR), 16'h7FFF, 16'h7FFF, 16'd0, 16'd6000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h0000_0000, 32'h7FFF_FFFF);
		program_controller(16'(pctm_pkg::MODE_INCR), 16'h8000, 16'h8000, 16'd0, 16'd6000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'd10, 32'd20);
	endtask

	// Spare mode drives 0 and keeps the state for the next incremental step
	task automatic test_spare_mode();
		program_controller(16'(MODE_SPARE), 16'd256, 16'd256, 16'd256, 16'd6000);
		@(posedge clk);
		write_reg(REG_NOT_FOUND, 16'hA5C3);
		cfg_valid <= 1'b0;
		send_sample(32'd0, 32'd777);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000);
		program_controller(16'(pctm_pkg::MODE_INCR), 16'd256, 16'd64, 16'd0, 16'd6000);
		send_sample(32'd3, 32'd0);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3:    return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	// Random phases: fresh settings, then a run of samples around the set point
	task automatic test_random_phases();
		logic [15:0] mode_word;
		logic [15:0] omax_word;
		logic [31:0] meas;
		logic [31:0] tgt;
		int          phase;
		int          count;
		int          start;
		phase = 0;
		start = samples_sent;
		while (samples_sent - start < RANDOM_ITEMS) begin
			mode_word = 16'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2: mode_word[1:0] = pctm_pkg::MODE_POS;
				3, 4, 5: mode_word[1:0] = pctm_pkg::MODE_SPEED;
				6, 7, 8: mode_word[1:0] = pctm_pkg::MODE_INCR;
				default: mode_word[1:0] = MODE_SPARE;
			endcase
			omax_word = 16'($urandom);
			case ($urandom_range(0, 5))
				0: omax_word[14:0] = '0;
				1: omax_word[14:0] = '1;
				2: omax_word[14:0] = pctm_pkg::OMAX_RESET;
				default: ;
			endcase
			program_controller(mode_word, pick_gain(), pick_gain(), pick_gain(), omax_word);
			quiet = (phase % 3 == 2);
			count = $urandom_range(15, 40);
			repeat (count) begin
				meas = $urandom;
				case ($urandom_range(0, 9))
					0:       tgt = meas;
					1, 2:    tgt = $urandom;
					3, 4:    tgt = meas + 32'($urandom_range(0, 200)) - 32'd100;
					default: tgt = meas + 32'($urandom_range(0, 6000)) - 32'd3000;
				endcase
				send_sample(meas, tgt);
			end
			phase++;
		end
		quiet = 1'b0;
	endtask

	// Receiver: change stall pattern whenever the random span runs out
	rx_pattern_t rx_pattern = RX_OPEN;
	int          rx_span    = 0;
	logic [1:0]  rx_tick    = '0;

	always @(posedge clk) begin
		rx_tick <= rx_tick + 2'd1;
		if (rx_span == 0) begin
			rx_span    <= $urandom_range(16, 80);
			rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
		end else begin
			rx_span <= rx_span - 1;
		end
		if (quiet)
			m_axis_tready <= 1'b1;
		else begin
			case (rx_pattern)
				RX_OPEN:         m_axis_tready <= 1'b1;
				RX_SPARSE:       m_axis_tready <= ($urandom_range(0, 2) != 0);
				RX_EVERY_FOURTH: m_axis_tready <= (rx_tick == 2'd0);
				default:         m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Check each drive item against the oldest expectation; watch for a hang
	always @(negedge clk) begin : watch_outputs
		logic [31:0] want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			drives_seen++;
			if (expected_drive.size() == 0) begin
				$error("drive: expected none, got %0d", $signed(m_axis_tdata));
				failures++;
			end else begin
				want = expected_drive.pop_front();
				if (m_axis_tdata !== want) begin
					$error("drive: expected %0d, got %0d", $signed(want),
						$signed(m_axis_tdata));
					failures++;
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready === 1'b1)
				|| (m_axis_tvalid === 1'b1 && m_axis_tready)
				|| (cfg_valid && cfg_ready === 1'b1))
			stalled_cycles = 0;
		else begin
			stalled_cycles++;
			if (stalled_cycles == IDLE_LIMIT) begin
				$display("pid_controller_three_mode: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_positional();
		test_speed();
		test_incremental();
		test_spare_mode();
		test_random_phases();
		drain_pipeline();
		$display("sent %0d samples: %0d positional, %0d speed, %0d incremental, %0d spare",
			samples_sent, law_items[pctm_pkg::MODE_POS], law_items[pctm_pkg::MODE_SPEED],
			law_items[pctm_pkg::MODE_INCR], law_items[MODE_SPARE]);
		$display("checked %0d drive items across %0d register writes,", drives_seen,
			reg_writes);
		$display("with sender gaps and receiver stalls");
		if (failures == 0)
			$display("pid_controller_three_mode: match");
		else
			$display("pid_controller_three_mode: mismatch");
		$finish;
	end

endmodule
